[sv/byte_ring_buffer_chunk_pop_macros.svh]
// Assertion macros for the byte ring buffer checker.
// Depends on nothing; included by the checker file.
`ifndef BYTE_RING_BUFFER_CHUNK_POP_MACROS_SVH
`define BYTE_RING_BUFFER_CHUNK_POP_MACROS_SVH

// clocked check, switched off while reset is held
`define BRBCP_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// clocked check that also runs through reset
`define BRBCP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[sv/brbcp_pkg.sv]
// Shared widths and opcodes of the byte ring buffer.
// No dependencies; used by the interfaces and the top level.
package brbcp_pkg;

    localparam int OP_W   = 3;
    localparam int CNT_W  = 13;
    localparam int OFF_W  = 12;
    localparam int DATA_W = 8;

    typedef logic [OP_W-1:0]   t_op;
    typedef logic [CNT_W-1:0]  t_cnt;
    typedef logic [OFF_W-1:0]  t_off;
    typedef logic [DATA_W-1:0] t_byte;

    localparam t_op OP_PUSH_BEGIN = 3'd0;
    localparam t_op OP_PUSH_BYTE  = 3'd1;
    localparam t_op OP_POP_START  = 3'd2;
    localparam t_op OP_READ_BYTE  = 3'd3;
    localparam t_op OP_POP_DONE   = 3'd4;
    localparam t_op OP_RESET      = 3'd5;

    localparam t_cnt CAP_RESET = 13'd4096;

endpackage

[sv/brbcp_in_if.sv]
// Command channel of the byte ring buffer: valid/ready and one command word.
// Depends on brbcp_pkg.
interface brbcp_in_if;
    import brbcp_pkg::*;

    logic  valid;
    logic  ready;
    t_op   opcode;
    t_cnt  message_length;
    t_byte push_data;
    t_off  read_offset;

    modport source (
        output valid, opcode, message_length, push_data, read_offset,
        input  ready
    );
    modport sink (
        input  valid, opcode, message_length, push_data, read_offset,
        output ready
    );
endinterface

[sv/brbcp_out_if.sv]
// Result channel of the byte ring buffer: valid/ready and one result word.
// Depends on brbcp_pkg.
interface brbcp_out_if;
    import brbcp_pkg::*;

    logic  valid;
    logic  ready;
    logic  status;
    t_off  chunk_offset;
    t_cnt  chunk_length;
    t_byte read_data;
    t_cnt  free_space;

    modport source (
        output valid, status, chunk_offset, chunk_length, read_data, free_space,
        input  ready
    );
    modport sink (
        input  valid, status, chunk_offset, chunk_length, read_data, free_space,
        output ready
    );
endinterface

[sv/byte_ring_buffer_chunk_pop.sv]
// Byte ring buffer with contiguous chunk pop. Every command word gives one
// result word. Push, pop and control commands stream at one word per clock
// while results drain; a read byte command also waits on the registered read
// of the single byte store. The result sits in one output register, so a new
// command is taken only when that register is empty or drains in the same
// cycle, and never while a read is pending. Writing capacity empties the
// buffer; there is no clearing pass after reset.
module byte_ring_buffer_chunk_pop #(
    parameter int DEPTH = 4096
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  brbcp_pkg::t_cnt     i_cfg_wdata,
    brbcp_in_if.sink            i_in,
    brbcp_out_if.source         o_out
);
    import brbcp_pkg::*;

    localparam int AW   = $clog2(DEPTH);
    localparam int XW   = (AW > CNT_W) ? AW : CNT_W;
    localparam int DCAP = (DEPTH > 8191) ? 8191 : DEPTH;
    localparam t_cnt CAP_MAX = CNT_W'(DCAP);

    t_byte r_store [DEPTH];
    t_byte r_mem_q;

    t_cnt r_cap, r_wp, r_rp, r_used, r_pend, r_rem;
    t_cnt n_wp, n_rp, n_used, n_pend, n_rem;
    logic r_rd_pend;

    logic  r_out_valid, r_status;
    t_off  r_coff;
    t_cnt  r_clen;
    t_byte r_rdata;
    t_cnt  r_free;
    logic  n_out_valid;

    logic  w_acc, w_wr_en, w_rd_en, w_status;
    t_cnt  w_cap, w_coff, w_clen, w_wp_inc;
    logic [XW-1:0] w_waddr_x, w_raddr_x;
    logic [AW-1:0] w_waddr, w_raddr;

    assign w_cap = (r_cap == '0) ? CNT_W'(1) : ((r_cap > CAP_MAX) ? CAP_MAX : r_cap);

    assign i_in.ready = !r_rd_pend && (!r_out_valid || o_out.ready);
    assign w_acc      = i_in.valid && i_in.ready;

    assign w_waddr_x = XW'(r_wp);
    assign w_raddr_x = XW'(i_in.read_offset);
    assign w_waddr   = w_waddr_x[AW-1:0];
    assign w_raddr   = w_raddr_x[AW-1:0];
    assign w_wp_inc  = r_wp + CNT_W'(1);

    always_comb begin
        n_wp     = r_wp;
        n_rp     = r_rp;
        n_used   = r_used;
        n_pend   = r_pend;
        n_rem    = r_rem;
        w_status = 1'b0;
        w_coff   = '0;
        w_clen   = '0;
        w_wr_en  = 1'b0;
        w_rd_en  = 1'b0;
        unique case (i_in.opcode)
            OP_PUSH_BEGIN: begin
                if (i_in.message_length <= w_cap - r_used) begin
                    n_rem = i_in.message_length;
                end else begin
                    n_rem    = '0;
                    w_status = 1'b1;
                end
            end
            OP_PUSH_BYTE: begin
                if (r_rem != '0 && r_used < w_cap) begin
                    w_wr_en = w_acc;
                    n_wp    = (w_wp_inc >= w_cap) ? '0 : w_wp_inc;
                    n_used  = r_used + CNT_W'(1);
                    n_rem   = r_rem - CNT_W'(1);
                end else begin
                    w_status = 1'b1;
                end
            end
            OP_POP_START: begin
                if (r_used == '0) begin
                    w_status = 1'b1;
                end else begin
                    w_coff = r_rp;
                    if (r_wp > r_rp) begin
                        w_clen = r_wp - r_rp;
                        n_rp   = r_wp;
                    end else begin
                        w_clen = w_cap - r_rp;
                        n_rp   = '0;
                    end
                    n_pend = w_clen;
                end
            end
            OP_READ_BYTE: begin
                if (CNT_W'(i_in.read_offset) < w_cap) begin
                    w_rd_en = w_acc;
                end else begin
                    w_status = 1'b1;
                end
            end
            OP_POP_DONE: begin
                n_used = (r_pend >= r_used) ? '0 : r_used - r_pend;
                n_pend = '0;
            end
            OP_RESET: begin
                n_wp   = '0;
                n_rp   = '0;
                n_used = '0;
                n_pend = '0;
                n_rem  = '0;
            end
            default: begin
                w_status = 1'b1;
            end
        endcase
    end

    always_comb begin
        priority if (r_rd_pend) begin
            n_out_valid = 1'b1;
        end else if (w_acc && i_in.opcode != OP_READ_BYTE) begin
            n_out_valid = 1'b1;
        end else if (o_out.ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap       <= CAP_RESET;
            r_wp        <= '0;
            r_rp        <= '0;
            r_used      <= '0;
            r_pend      <= '0;
            r_rem       <= '0;
            r_rd_pend   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_rd_pend   <= w_acc && i_in.opcode == OP_READ_BYTE;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_cap  <= i_cfg_wdata;
                r_wp   <= '0;
                r_rp   <= '0;
                r_used <= '0;
                r_pend <= '0;
                r_rem  <= '0;
            end else if (w_acc) begin
                r_wp   <= n_wp;
                r_rp   <= n_rp;
                r_used <= n_used;
                r_pend <= n_pend;
                r_rem  <= n_rem;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_status <= w_status;
            r_coff   <= w_coff[OFF_W-1:0];
            r_clen   <= w_clen;
            r_rdata  <= '0;
            r_free   <= w_cap - n_used;
        end else if (r_rd_pend && !r_status) begin
            r_rdata <= r_mem_q;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_store[w_waddr] <= i_in.push_data;
        end
        if (w_rd_en) begin
            r_mem_q <= r_store[w_raddr];
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.status       = r_status;
    assign o_out.chunk_offset = r_coff;
    assign o_out.chunk_length = r_clen;
    assign o_out.read_data    = r_rdata;
    assign o_out.free_space   = r_free;

endmodule

[sv/brbcp_checker.sv]
// Port-level checks of the byte ring buffer, bound to the top level.
// Depends on the macro header and byte_ring_buffer_chunk_pop.
`include "byte_ring_buffer_chunk_pop_macros.svh"

module brbcp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic        i_status,
    input logic [12:0] i_chunk_length,
    input logic [7:0]  i_read_data
);
    `BRBCP_ASSERT(a_hold_word, i_clk, i_rst_n, i_out_valid && !i_out_ready |=> i_out_valid, "result word dropped while stalled")
    `BRBCP_ASSERT(a_chunk_ok, i_clk, i_rst_n, i_out_valid && i_chunk_length != 13'd0 |-> !i_status, "chunk reported with failing status")
    `BRBCP_ASSERT(a_read_excl, i_clk, i_rst_n, i_out_valid && i_read_data != 8'd0 |-> !i_status && i_chunk_length == 13'd0, "read byte mixed with chunk or failure")
    `BRBCP_ASSERT_ALWAYS(a_reset_idle, i_clk, !i_rst_n |=> !i_out_valid, "result word present after reset")
endmodule

bind byte_ring_buffer_chunk_pop brbcp_checker u_brbcp_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_status       (o_out.status),
    .i_chunk_length (o_out.chunk_length),
    .i_read_data    (o_out.read_data)
);

[tb/sv/brbcp_result_checker.sv]
`timescale 1ns / 100ps
// Result checker for the byte ring buffer: mirrors the buffer from accepted command
// words, queues the expected result words and compares them as they leave.
// Depends on brbcp_pkg, brbcp_in_if and brbcp_out_if.
module brbcp_result_checker
    import brbcp_pkg::*;
#(
    parameter int DEPTH       = 4096,
    parameter int MAX_REPORTS = 10
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  t_cnt             i_cfg_wdata,
    brbcp_in_if              i_cmd,
    brbcp_out_if             i_res,
    output int               o_err_count,
    output int               o_pending,
    output int               o_checked,
    output t_cnt             o_cap,
    output t_cnt             o_room,
    output logic [DEPTH-1:0] o_written
);

    typedef struct packed {
        logic  status;
        t_off  chunk_offset;
        t_cnt  chunk_length;
        t_byte read_data;
        t_cnt  free_space;
    } t_result;

    t_byte            store_mem [DEPTH];
    logic [DEPTH-1:0] written_map;
    t_cnt             cap_reg;
    t_cnt             used_cnt;
    t_cnt             pend_pop;
    t_cnt             bytes_left;
    t_off             wr_ptr;
    t_off             rd_ptr;
    t_result          expected_q [$];
    int               errs;
    int               compared;
    int               waiting;

    function automatic t_cnt clamp_capacity(t_cnt raw);
        if (raw == '0)
            return t_cnt'(1);
        if (raw > t_cnt'(DEPTH))
            return t_cnt'(DEPTH);
        return raw;
    endfunction

    function automatic void clear_buffer();
        wr_ptr     = '0;
        rd_ptr     = '0;
        used_cnt   = '0;
        pend_pop   = '0;
        bytes_left = '0;
    endfunction

    function automatic t_result apply_command(t_op op, t_cnt msg_len, t_byte data, t_off offs);
        t_cnt    cap;
        t_result r;
        cap = clamp_capacity(cap_reg);
        r   = '0;
        if ({1'b0, rd_ptr} >= cap) rd_ptr = '0;
        if ({1'b0, wr_ptr} >= cap) wr_ptr = '0;
        if (used_cnt > cap) used_cnt = cap;
        case (op)
            OP_PUSH_BEGIN: begin
                if (msg_len <= cap - used_cnt) begin
                    bytes_left = msg_len;
                end else begin
                    bytes_left = '0;
                    r.status   = 1'b1;
                end
            end
            OP_PUSH_BYTE: begin
                if (bytes_left != '0 && used_cnt < cap) begin
                    store_mem[wr_ptr]   = data;
                    written_map[wr_ptr] = 1'b1;
                    if ({1'b0, wr_ptr} + t_cnt'(1) >= cap)
                        wr_ptr = '0;
                    else
                        wr_ptr = wr_ptr + t_off'(1);
                    used_cnt   = used_cnt + t_cnt'(1);
                    bytes_left = bytes_left - t_cnt'(1);
                end else begin
                    r.status = 1'b1;
                end
            end
            OP_POP_START: begin
                if (used_cnt == '0) begin
                    r.status = 1'b1;
                end else begin
                    r.chunk_offset = rd_ptr;
                    if (wr_ptr > rd_ptr) begin
                        r.chunk_length = {1'b0, wr_ptr - rd_ptr};
                        rd_ptr         = wr_ptr;
                    end else begin
                        r.chunk_length = cap - {1'b0, rd_ptr};
                        rd_ptr         = '0;
                    end
                    pend_pop = r.chunk_length;
                end
            end
            OP_READ_BYTE: begin
                if ({1'b0, offs} < cap)
                    r.read_data = store_mem[offs];
                else
                    r.status = 1'b1;
            end
            OP_POP_DONE: begin
                used_cnt = (pend_pop >= used_cnt) ? '0 : used_cnt - pend_pop;
                pend_pop = '0;
            end
            OP_RESET: begin
                clear_buffer();
            end
            default: begin
                r.status = 1'b1;
            end
        endcase
        r.free_space = cap - used_cnt;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            cap_reg     = CAP_RESET;
            clear_buffer();
            written_map = '0;
            expected_q.delete();
            errs        = 0;
            compared    = 0;
        end else begin
            if (i_cfg_we) begin
                cap_reg = i_cfg_wdata;
                clear_buffer();
            end
            if (i_res.valid && i_res.ready) begin
                got = {i_res.status, i_res.chunk_offset, i_res.chunk_length,
                       i_res.read_data, i_res.free_space};
                if (expected_q.size() == 0) begin
                    errs++;
                    if (errs <= MAX_REPORTS)
                        $display("%0t: result word with none expected: st=%0d off=%0d len=%0d rd=%02h free=%0d",
                                 $time, got.status, got.chunk_offset, got.chunk_length,
                                 got.read_data, got.free_space);
                end else begin
                    want = expected_q.pop_front();
                    compared++;
                    if (got !== want) begin
                        errs++;
                        if (errs <= MAX_REPORTS)
                            $display("%0t: mismatch want st=%0d off=%0d len=%0d rd=%02h free=%0d, got st=%0d off=%0d len=%0d rd=%02h free=%0d",
                                     $time, want.status, want.chunk_offset, want.chunk_length,
                                     want.read_data, want.free_space, got.status,
                                     got.chunk_offset, got.chunk_length, got.read_data,
                                     got.free_space);
                    end
                end
            end
            if (i_cmd.valid && i_cmd.ready)
                expected_q.push_back(apply_command(i_cmd.opcode, i_cmd.message_length,
                                                   i_cmd.push_data, i_cmd.read_offset));
        end
        waiting = expected_q.size();
    end

    assign o_err_count = errs;
    assign o_pending   = waiting;
    assign o_checked   = compared;
    assign o_cap       = clamp_capacity(cap_reg);
    assign o_room      = clamp_capacity(cap_reg) - used_cnt;
    assign o_written   = written_map;

endmodule

[tb/sv/tb_byte_ring_buffer_chunk_pop.sv]
`timescale 1ns / 100ps
// Top of the byte ring buffer bench: clock, reset, command words, result back-pressure
// and the verdict. Depends on brbcp_pkg, both channel interfaces,
// byte_ring_buffer_chunk_pop and brbcp_result_checker.
module tb_byte_ring_buffer_chunk_pop;
    import brbcp_pkg::*;

    localparam int  DEPTH      = 4096;
    localparam int  IDLE_LIMIT = 2000;
    localparam int  LONG_HOLD  = 300;
    localparam int  PHASE_WORDS = 92;
    localparam t_op OP_SPARE_6 = 3'd6;
    localparam t_op OP_SPARE_7 = 3'd7;

    logic             clk;
    logic             rst_n;
    logic             cfg_we;
    t_cnt             cfg_wdata;
    int               err_count;
    int               pending;
    int               checked;
    t_cnt             cap_now;
    t_cnt             room;
    logic [DEPTH-1:0] written;
    int               words_sent;
    int               useful_words;
    int               cap_writes;
    int               idle_cycles;
    int               tx_calm;
    int               rx_calm;
    bit               hold_req;
    t_cnt             cap_plan [10];

    brbcp_in_if  cmd ();
    brbcp_out_if res ();

    byte_ring_buffer_chunk_pop #(.DEPTH(DEPTH)) i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_in        (cmd),
        .o_out       (res)
    );

    brbcp_result_checker #(.DEPTH(DEPTH)) i_chk (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_cmd       (cmd),
        .i_res       (res),
        .o_err_count (err_count),
        .o_pending   (pending),
        .o_checked   (checked),
        .o_cap       (cap_now),
        .o_room      (room),
        .o_written   (written)
    );

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    task automatic send_word(input t_op op, input t_cnt len, input t_byte data,
                             input t_off offs);
        int gap;
        if (tx_calm > 0) begin
            gap = 0;
            tx_calm--;
        end else begin
            gap = $urandom_range(0, 9);
            if ($urandom_range(0, 39) == 0) tx_calm = 25;
        end
        if (gap > 0) begin
            cmd.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        cmd.valid          <= 1'b1;
        cmd.opcode         <= op;
        cmd.message_length <= len;
        cmd.push_data      <= data;
        cmd.read_offset    <= offs;
        @(posedge clk);
        while (!cmd.ready) @(posedge clk);
        words_sent++;
        @(negedge clk);
    endtask

    task automatic send_ctl(input t_op op);
        send_word(op, t_cnt'($urandom_range(0, 4096)), t_byte'($urandom), t_off'($urandom));
    endtask

    task automatic push_byte(input t_byte data);
        send_word(OP_PUSH_BYTE, t_cnt'($urandom_range(0, 4096)), data, t_off'($urandom));
    endtask

    task automatic push_message(input int len);
        send_word(OP_PUSH_BEGIN, t_cnt'(len), t_byte'($urandom), t_off'($urandom));
        repeat (len) push_byte(t_byte'($urandom));
        useful_words += len + 1;
    endtask

    // only offsets already written, or ones beyond the capacity
    task automatic read_word();
        int start;
        int pick;
        pick = -1;
        if ($urandom_range(0, 3) != 0) begin
            start = $urandom_range(0, int'(cap_now) - 1);
            for (int i = 0; i < int'(cap_now) && pick < 0; i++)
                if (written[(start + i) % int'(cap_now)]) pick = (start + i) % int'(cap_now);
        end
        if (pick < 0 && int'(cap_now) < DEPTH)
            pick = $urandom_range(int'(cap_now), DEPTH - 1);
        if (pick >= 0) begin
            send_word(OP_READ_BYTE, t_cnt'($urandom_range(0, 4096)), t_byte'($urandom),
                      t_off'(pick));
            useful_words++;
        end
    endtask

    task automatic set_capacity(input t_cnt value);
        cmd.valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (4) @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        cap_writes++;
        @(negedge clk);
    endtask

    task automatic random_transaction();
        int  r;
        int  len;
        int  span;
        t_op op;
        r = $urandom_range(0, 99);
        if (r < 50) begin
            span = (int'(room) < 12) ? int'(room) : 12;
            len  = $urandom_range(0, span);
            if (int'(room) <= 64 && $urandom_range(0, 9) == 0) len = int'(room);
            push_message(len);
        end else if (r < 65) begin
            send_ctl(OP_POP_START);
            useful_words++;
            if ($urandom_range(0, 3) != 0) begin
                send_ctl(OP_POP_DONE);
                useful_words++;
            end
        end else if (r < 77) begin
            read_word();
        end else if (r < 80) begin
            send_ctl(OP_RESET);
            useful_words++;
        end else if (r < 85) begin
            send_ctl(OP_POP_DONE);
            useful_words++;
        end else if (r < 92) begin
            span = (int'(room) < 12) ? int'(room) + 3 : 15;
            len  = $urandom_range(0, span);
            send_word(OP_PUSH_BEGIN, t_cnt'(len), t_byte'($urandom), t_off'($urandom));
            repeat ($urandom_range(0, len + 2)) push_byte(t_byte'($urandom));
        end else begin
            op = t_op'($urandom_range(0, 7));
            if (op == OP_READ_BYTE)
                read_word();
            else
                send_ctl(op);
        end
    endtask

    initial begin
        int stall;
        res.ready = 1'b0;
        rx_calm   = 0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever begin
            if (hold_req) begin
                stall    = LONG_HOLD;
                hold_req = 1'b0;
            end else if (rx_calm > 0) begin
                stall = 0;
                rx_calm--;
            end else begin
                stall = $urandom_range(0, 9);
                if ($urandom_range(0, 39) == 0) rx_calm = 30;
            end
            if (stall > 0) begin
                res.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            res.ready <= 1'b1;
            @(posedge clk);
            while (!res.valid) @(posedge clk);
            @(negedge clk);
        end
    end

    initial idle_cycles = 0;

    always @(posedge clk) begin
        if (!rst_n || (cmd.valid && cmd.ready) || (res.valid && res.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no word moved for %0d cycles, %0d results outstanding",
                     idle_cycles, pending);
            $display("tb_byte_ring_buffer_chunk_pop: errors");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int target;
        rst_n              = 1'b0;
        cfg_we             = 1'b0;
        cfg_wdata          = '0;
        cmd.valid          = 1'b0;
        cmd.opcode         = OP_PUSH_BEGIN;
        cmd.message_length = '0;
        cmd.push_data      = '0;
        cmd.read_offset    = '0;
        words_sent         = 0;
        useful_words       = 0;
        cap_writes         = 0;
        tx_calm            = 0;
        hold_req           = 1'b0;
        cap_plan = '{13'd8191, 13'd16, 13'd5, 13'd1, 13'd4095, 13'd7, 13'd100, 13'd2,
                     13'd4096, 13'd0};
        cap_plan[9] = t_cnt'($urandom_range(3, 300));

        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset capacity: empty, unannounced and abandoned messages, reads, repeated pop, reset and spare opcodes
        send_ctl(OP_POP_START);
        push_byte(8'h3C);
        send_ctl(OP_POP_DONE);
        send_word(OP_PUSH_BEGIN, 13'd4096, t_byte'($urandom), t_off'($urandom));
        send_word(OP_PUSH_BEGIN, 13'd0, t_byte'($urandom), t_off'($urandom));
        push_byte(8'hC3);
        send_word(OP_PUSH_BEGIN, 13'd3, t_byte'($urandom), t_off'($urandom));
        push_byte(8'h00);
        push_byte(8'hFF);
        push_byte(8'hA5);
        send_word(OP_READ_BYTE, 13'd4096, 8'hFF, 12'd0);
        send_word(OP_READ_BYTE, 13'd0, 8'h00, 12'd2);
        send_ctl(OP_POP_START);
        send_ctl(OP_POP_START);
        send_ctl(OP_POP_DONE);
        send_ctl(OP_RESET);
        send_ctl(OP_SPARE_6);
        send_ctl(OP_SPARE_7);

        // zero capacity acts as one byte
        set_capacity(13'd0);
        send_word(OP_PUSH_BEGIN, 13'd2, t_byte'($urandom), t_off'($urandom));
        send_word(OP_PUSH_BEGIN, 13'd1, t_byte'($urandom), t_off'($urandom));
        push_byte(8'h5A);
        send_word(OP_READ_BYTE, 13'd0, 8'h00, 12'd0);
        send_word(OP_READ_BYTE, 13'd0, 8'h00, 12'd4095);
        send_ctl(OP_POP_START);
        send_ctl(OP_POP_DONE);

        foreach (cap_plan[p]) begin
            set_capacity(cap_plan[p]);
            if (p == 1) begin
                hold_req = 1'b1;
                tx_calm  = 60;
            end
            target = words_sent + PHASE_WORDS;
            while (words_sent < target) random_transaction();
        end

        cmd.valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (10) @(negedge clk);

        $display("run: %0d command words (%0d on live data) over %0d capacity settings",
                 words_sent, useful_words, cap_writes + 1);
        $display("run: %0d results compared", checked);
        if (err_count == 0 && pending == 0)
            $display("tb_byte_ring_buffer_chunk_pop: clean");
        else
            $display("tb_byte_ring_buffer_chunk_pop: errors");
        $finish;
    end

endmodule
